[hw/rtl/fqd_pkg.sv]
// shared types and codes for the fifo queue with delete
package fqd_pkg;

    localparam int IN_VALUE_W  = 32;
    localparam int OUT_VALUE_W = 32;
    localparam int LENGTH_W    = 5;
    localparam int KIND_W      = 2;

    localparam logic [KIND_W-1:0] KIND_ENQ = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DEQ_DATA,
        ST_SCAN,
        ST_SHIFT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                   status;
        logic [OUT_VALUE_W-1:0] value;
        logic [LENGTH_W-1:0]    length;
    } result_t;

endpackage

[hw/rtl/fifo_queue_with_delete_unit.sv]
// top level: fifo queue of nonzero tags with enqueue, dequeue and delete by value
//
// input words on s_*: s_tuser carries the operation (0 enqueue, 1 dequeue,
// 2 delete first match), s_tdata the value. one result word per input on m_*:
// m_tuser is the error flag, m_tdata holds the dequeued value and the length.
// an enqueue or a failing check goes from decode straight to the result, a
// dequeue reads its data first, and a delete reads the ring one entry a
// cycle through a single ring-step incrementer and compare, then moves each
// younger entry up one slot, one read and one write per cycle on the memory.
// s_tready is high only while the sequencer is idle, so one input is in work
// at a time. results wait in an output register: a stalled receiver holds
// m_tvalid and data, while the next input may already be taken and worked
// on; it then waits for the register to free. reset empties the queue at
// once (head and count cleared), no memory sweep is needed since only
// written entries are ever read.
module fifo_queue_with_delete_unit import fqd_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // item_value[31:0]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_value[31:0], length[36:32], zero pad[39:37]
    output logic [0:0]  m_tuser    // status[0]
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                   res_valid;
    logic                   res_ready;
    result_t                res;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg, m_res_next;

    fqd_seq #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW),
        .CW          (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_value  (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    fqd_store #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register frees when empty or when its word is taken
    assign res_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {3'b000, m_res_reg.length, m_res_reg.value};
    assign m_tuser[0] = m_res_reg.status;

endmodule

[hw/rtl/fqd_store.sv]
// entry memory: one write port, one registered read port
module fqd_store import fqd_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = 4
)
(
    input  logic                   clk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  logic [VALUE_WIDTH-1:0] wdata,
    input  logic [AW-1:0]          raddr,
    output logic [VALUE_WIDTH-1:0] rdata
);

    logic [VALUE_WIDTH-1:0] entry_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[waddr] <= wdata;
        end
        rdata_reg <= entry_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/fqd_seq.sv]
// sequencer: decodes an operation and walks the ring for delete scan and compaction
module fqd_seq import fqd_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = 4,
    parameter int CW          = 5
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [KIND_W-1:0]      in_kind,
    input  logic [IN_VALUE_W-1:0]  in_value,
    output logic                   res_valid,
    input  logic                   res_ready,
    output result_t                res,
    output logic                   mem_we,
    output logic [AW-1:0]          mem_waddr,
    output logic [VALUE_WIDTH-1:0] mem_wdata,
    output logic [AW-1:0]          mem_raddr,
    input  logic [VALUE_WIDTH-1:0] mem_rdata
);

    state_t                 state_reg, state_next;
    logic [AW-1:0]          head_reg, head_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [AW-1:0]          ptr_reg, ptr_next;
    logic [AW-1:0]          wr_reg, wr_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic                   status_reg, status_next;
    logic [VALUE_WIDTH-1:0] outv_reg, outv_next;

    logic [IN_VALUE_W+VALUE_WIDTH-1:0]  value_ext;
    logic [VALUE_WIDTH-1:0]             value_in;
    logic [AW:0]                        enq_sum;
    logic [AW:0]                        enq_wrap;
    logic [AW-1:0]                      enq_slot;
    logic [AW-1:0]                      ptr_inc;
    logic [CW-1:0]                      idx_inc;
    logic                               more;
    logic                               match;
    logic                               full;
    logic                               empty;
    logic                               zero_val;
    logic [OUT_VALUE_W+VALUE_WIDTH-1:0] outv_ext;
    logic [LENGTH_W+CW-1:0]             len_ext;

    // input value is taken in its low VALUE_WIDTH bits
    assign value_ext = {{VALUE_WIDTH{1'b0}}, in_value};
    assign value_in  = value_ext[VALUE_WIDTH-1:0];

    // tail slot for enqueue, sum stays below twice the depth
    assign enq_sum  = {1'b0, head_reg} + (AW+1)'(count_reg);
    assign enq_wrap = (enq_sum >= (AW+1)'(DEPTH)) ? enq_sum - (AW+1)'(DEPTH) : enq_sum;
    assign enq_slot = enq_wrap[AW-1:0];

    // shared ring step, also advances head on dequeue
    assign ptr_inc = (ptr_reg == AW'(DEPTH - 1)) ? '0 : ptr_reg + AW'(1);

    assign idx_inc  = idx_reg + CW'(1);
    assign more     = idx_inc < count_reg;
    assign match    = mem_rdata == value_reg;
    assign full     = count_reg == CW'(DEPTH);
    assign empty    = count_reg == '0;
    assign zero_val = value_reg == '0;

    assign in_ready  = state_reg == ST_IDLE;
    assign res_valid = state_reg == ST_RESULT;

    assign outv_ext   = {{OUT_VALUE_W{1'b0}}, outv_reg};
    assign len_ext    = {{LENGTH_W{1'b0}}, count_reg};
    assign res.status = status_reg;
    assign res.value  = outv_ext[OUT_VALUE_W-1:0];
    assign res.length = len_ext[LENGTH_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (kind_reg)
                    KIND_DEQ: state_next = empty ? ST_RESULT : ST_DEQ_DATA;
                    KIND_DEL: state_next = (zero_val || empty) ? ST_RESULT : ST_SCAN;
                    default:  state_next = ST_RESULT;
                endcase
            end
            ST_DEQ_DATA: state_next = ST_RESULT;
            ST_SCAN:
            begin
                if (!more)
                begin
                    state_next = ST_RESULT;
                end
                else if (match)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (!more)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        ptr_next    = ptr_reg;
        wr_next     = wr_reg;
        kind_next   = kind_reg;
        value_next  = value_reg;
        status_next = status_reg;
        outv_next   = outv_reg;
        mem_we      = 1'b0;
        mem_waddr   = wr_reg;
        mem_wdata   = mem_rdata;
        mem_raddr   = head_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = in_kind;
                    value_next = value_in;
                end
            end
            ST_DECODE:
            begin
                status_next = 1'b1;
                outv_next   = '0;
                ptr_next    = head_reg;
                idx_next    = '0;
                case (kind_reg)
                    KIND_ENQ:
                    begin
                        if (!zero_val && !full)
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = enq_slot;
                            mem_wdata   = value_reg;
                            count_next  = count_reg + CW'(1);
                            status_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        // dequeue and delete both start reading at head
                        mem_raddr = head_reg;
                    end
                endcase
            end
            ST_DEQ_DATA:
            begin
                outv_next   = mem_rdata;
                status_next = 1'b0;
                head_next   = ptr_inc;
                count_next  = count_reg - CW'(1);
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    status_next = 1'b0;
                    wr_next     = ptr_reg;
                end
                if (more)
                begin
                    mem_raddr = ptr_inc;
                    ptr_next  = ptr_inc;
                    idx_next  = idx_inc;
                end
                else if (match)
                begin
                    // match on the youngest entry, nothing to close up
                    count_next = count_reg - CW'(1);
                end
            end
            ST_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = wr_reg;
                mem_wdata = mem_rdata;
                if (more)
                begin
                    mem_raddr = ptr_inc;
                    ptr_next  = ptr_inc;
                    wr_next   = ptr_reg;
                    idx_next  = idx_inc;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        ptr_reg    <= ptr_next;
        wr_reg     <= wr_next;
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        outv_reg   <= outv_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (idx_reg < count_reg))
        else $error("compaction walked past the tail");

    a_head_moves_on_deq: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(head_reg) |-> $past(state_reg == ST_DEQ_DATA))
        else $error("head moved outside a dequeue");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |->
            (count_reg == $past(count_reg) + CW'(1) ||
             count_reg + CW'(1) == $past(count_reg)))
        else $error("entry count changed by more than one");

endmodule
